### sv/snt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snt_pkg
// Shared widths, flag codes and word types of the neuron tick pipeline.
// ----------------------------------------------------------------------------
package snt_pkg;

   localparam int LEVEL_BITS    = 32;
   localparam int MAG_BITS      = LEVEL_BITS - 1;
   localparam int VIT_BITS      = 16;
   localparam int TICK_BITS     = 32;
   localparam int FLAG_BITS     = 5;

   localparam logic [FLAG_BITS-1:0] FLAG_SPIKED   = 5'b00010;
   localparam logic [FLAG_BITS-1:0] FLAG_DEAD     = 5'b00100;
   localparam logic [FLAG_BITS-1:0] FLAG_RECEIVER = 5'b10000;

   localparam logic [VIT_BITS-1:0] VIT_ONE  = VIT_BITS'(1);
   localparam logic [MAG_BITS-1:0] MAG_ZERO = '0;

   typedef struct packed {
      logic [TICK_BITS-1:0]         tick_now;
      logic signed [LEVEL_BITS-1:0] level_in;
      logic [FLAG_BITS-1:0]         flags_in;
      logic [VIT_BITS-1:0]          vitality_in;
      logic [TICK_BITS-1:0]         last_spike_in;
      logic [MAG_BITS-1:0]          fire_threshold;
      logic [MAG_BITS-1:0]          leak_amount;
      logic [VIT_BITS-1:0]          spike_cost;
      logic [VIT_BITS-1:0]          vitality_max;
   } req_type;

   typedef struct packed {
      logic [MAG_BITS-1:0]  level_out;
      logic [FLAG_BITS-1:0] flags_out;
      logic [VIT_BITS-1:0]  vitality_out;
      logic [TICK_BITS-1:0] last_spike_out;
   } rsp_type;

   // first stage: compares and differences
   typedef struct packed {
      logic [TICK_BITS-1:0] tick_now;
      logic [TICK_BITS-1:0] last_spike;
      logic [FLAG_BITS-1:0] flags;
      logic [VIT_BITS-1:0]  vitality;
      logic [VIT_BITS-1:0]  vitality_max;
      logic [VIT_BITS-1:0]  vit_less_cost;
      logic [MAG_BITS-1:0]  level_mag;
      logic [MAG_BITS-1:0]  leak_diff;
      logic                 leak_ok;
      logic                 negative;
      logic                 at_threshold;
      logic                 can_afford;
   } cls_type;

   // second stage: record after spike, death or leak
   typedef struct packed {
      logic [MAG_BITS-1:0]  level;
      logic [FLAG_BITS-1:0] flags;
      logic [VIT_BITS-1:0]  vitality;
      logic [VIT_BITS-1:0]  vitality_max;
      logic [TICK_BITS-1:0] last_spike;
      logic                 recover;
   } sel_type;

endpackage
`default_nettype wire

### sv/snt_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snt_classify
// First stage: threshold, leak and cost compares and the differences.
// ----------------------------------------------------------------------------
module snt_classify (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire snt_pkg::req_type req_word,
   output logic                 cls_valid,
   input  wire logic            cls_ready,
   output snt_pkg::cls_type     cls_word
);
   import snt_pkg::*;

   logic    valid_ff, valid_in;
   cls_type word_ff, word_in;
   logic    load;

   assign req_ready = !valid_ff || cls_ready;
   assign load      = req_valid && req_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_comb begin
      word_in.tick_now      = req_word.tick_now;
      word_in.last_spike    = req_word.last_spike_in;
      word_in.flags         = req_word.flags_in;
      word_in.vitality      = req_word.vitality_in;
      word_in.vitality_max  = req_word.vitality_max;
      word_in.vit_less_cost = req_word.vitality_in - req_word.spike_cost;
      word_in.level_mag     = req_word.level_in[MAG_BITS-1:0];
      word_in.leak_diff     = req_word.level_in[MAG_BITS-1:0] - req_word.leak_amount;
      word_in.leak_ok       = req_word.level_in[MAG_BITS-1:0] >= req_word.leak_amount;
      word_in.negative      = req_word.level_in[LEVEL_BITS-1];
      word_in.at_threshold  = req_word.level_in[MAG_BITS-1:0] >= req_word.fire_threshold;
      word_in.can_afford    = req_word.vitality_in > req_word.spike_cost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_word  = word_ff;

endmodule
`default_nettype wire

### sv/snt_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snt_select
// Second stage: spike, death, leak or clamp, and the flag update.
// ----------------------------------------------------------------------------
module snt_select (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cls_valid,
   output logic                  cls_ready,
   input  wire snt_pkg::cls_type cls_word,
   output logic                  sel_valid,
   input  wire logic             sel_ready,
   output snt_pkg::sel_type      sel_word
);
   import snt_pkg::*;

   logic    valid_ff, valid_in;
   sel_type word_ff, word_in;
   logic    load;

   assign cls_ready = !valid_ff || sel_ready;
   assign load      = cls_valid && cls_ready;
   assign valid_in  = cls_ready ? cls_valid : valid_ff;

   always_comb begin
      word_in.level        = cls_word.level_mag;
      word_in.flags        = cls_word.flags;
      word_in.vitality     = cls_word.vitality;
      word_in.vitality_max = cls_word.vitality_max;
      word_in.last_spike   = cls_word.last_spike;
      word_in.recover      = 1'b0;
      if ((cls_word.flags & FLAG_DEAD) == '0) begin
         word_in.flags = cls_word.flags & ~FLAG_SPIKED;
         if ((cls_word.flags & FLAG_RECEIVER) == '0) begin
            word_in.recover = 1'b1;
            if (cls_word.negative) begin
               word_in.level = MAG_ZERO;
            end else if (cls_word.at_threshold) begin
               word_in.level = MAG_ZERO;
               if (cls_word.can_afford) begin
                  word_in.vitality   = cls_word.vit_less_cost;
                  word_in.flags      = word_in.flags | FLAG_SPIKED;
                  word_in.last_spike = cls_word.tick_now;
               end else begin
                  word_in.vitality = cls_word.vitality_max;
                  word_in.flags    = word_in.flags | FLAG_DEAD;
               end
            end else begin
               word_in.level = cls_word.leak_ok ? cls_word.leak_diff : MAG_ZERO;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign sel_valid = valid_ff;
   assign sel_word  = word_ff;

endmodule
`default_nettype wire

### sv/snt_recover.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snt_recover
// Third stage: vitality recovery by one below the ceiling, result register.
// ----------------------------------------------------------------------------
module snt_recover (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             sel_valid,
   output logic                  sel_ready,
   input  wire snt_pkg::sel_type sel_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output snt_pkg::rsp_type      rsp_word
);
   import snt_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;
   logic    load;

   assign sel_ready = !valid_ff || rsp_ready;
   assign load      = sel_valid && sel_ready;
   assign valid_in  = sel_ready ? sel_valid : valid_ff;

   always_comb begin
      word_in.level_out      = sel_word.level;
      word_in.flags_out      = sel_word.flags;
      word_in.last_spike_out = sel_word.last_spike;
      if (sel_word.recover && (sel_word.vitality < sel_word.vitality_max)) begin
         word_in.vitality_out = sel_word.vitality + VIT_ONE;
      end else begin
         word_in.vitality_out = sel_word.vitality;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
`default_nettype wire

### sv/spiking_neuron_tick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spiking_neuron_tick
// One tick of a leaky integrate-and-fire neuron with a vitality budget.
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one neuron record plus its layer parameters per word
//   rsp_ channel: the updated record, one word per request word, in order
//   path: each req word passes three register stages in order (compares,
//   select, vitality recovery with the result register) before its rsp
//   word is presented with rsp_valid
//   throughput: one word per cycle while rsp_ready is high; each stage takes
//   a new word whenever it is empty or its word moves on in the same cycle
//   stall: while rsp_ready is low the result register holds its word and
//   the stages behind it keep filling; req_ready drops once all three hold
//   a word, nothing is dropped or repeated
//   reset: synchronous, clears all stage valid bits, block is ready at once
//   no configuration registers, no state kept between words
// ----------------------------------------------------------------------------
module spiking_neuron_tick (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire snt_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output snt_pkg::rsp_type      rsp_word
);
   import snt_pkg::*;

   logic    cls_valid, cls_ready;
   cls_type cls_word;
   logic    sel_valid, sel_ready;
   sel_type sel_word;

   snt_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cls_valid (cls_valid),
      .cls_ready (cls_ready),
      .cls_word  (cls_word)
   );

   snt_select u_select (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_ready (cls_ready),
      .cls_word  (cls_word),
      .sel_valid (sel_valid),
      .sel_ready (sel_ready),
      .sel_word  (sel_word)
   );

   snt_recover u_recover (
      .clock     (clock),
      .reset     (reset),
      .sel_valid (sel_valid),
      .sel_ready (sel_ready),
      .sel_word  (sel_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   // pipeline empties on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // an empty result register lets every stage advance
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty result register");

   // a drained result word frees the whole pipe
   a_ready_on_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("req_ready low while result drains");

   // a live sender may spike or die, never both
   a_spike_or_die: assert property (@(posedge clock) disable iff (reset)
      sel_valid && sel_word.recover |->
         !(((sel_word.flags & FLAG_SPIKED) != '0) && ((sel_word.flags & FLAG_DEAD) != '0)))
      else $error("live neuron marked both spiked and dead");
`endif

endmodule
`default_nettype wire
